FILE: design/rfbps_pkg.sv
// shared geometry, types and request codes for the ring fifo with bulk pop and skip
// no dependencies; imported by the design
package rfbps_pkg;

  // fifo geometry, fixed for the whole design
  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_SKIP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t            req_type;
    logic [WORD_BITS-1:0] data;
    logic [CNT_BITS-1:0]  count;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_out;
    logic                 word_valid;
    logic                 last;
    logic                 accepted;
    logic [IDX_BITS-1:0]  used_count;
    logic [IDX_BITS-1:0]  free_count;
  } result_t;

endpackage

FILE: design/rfbps_ram.sv
// simple dual-port slot memory, one write and one registered read per cycle
// no package dependencies; instantiated by ring_fifo_bulk_pop_skip
module rfbps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ring_fifo_bulk_pop_skip.sv
// top level of the ring fifo with bulk pop and skip
// depends on rfbps_pkg and rfbps_ram
//
// usage
//   a request is a transfer on the item port, taken at a rising edge where
//   start is high and busy is low. results come back on the result port, each
//   shown for exactly one cycle with done high; the receiver cannot stall them
//   - push, skip and clear: one result, shown the cycle after the transfer;
//     the block takes a new request in that same cycle
//   - pop of n words (n = min(count, used)): the first word goes through the
//     ST_POP read issue, the memory read register and the result register,
//     then one word per cycle; busy stays high until the last word is shown.
//     the rate is set by the memory's single read port (one slot per cycle)
//   - pop with nothing to give: one empty result the next cycle, like a push
//   the fifo keeps one slot free and holds at most DEPTH-1 words
//   reset (rst, synchronous) empties the fifo and zeroes both indices; slot
//   contents are not cleared and are never read before a push writes them
module ring_fifo_bulk_pop_skip
  import rfbps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int AW = IDX_BITS;
  localparam int CW = (AW > CNT_BITS) ? AW : CNT_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  state_t         state;
  logic [AW-1:0]  read_index;
  logic [AW-1:0]  write_index;
  logic [AW-1:0]  fill_level;
  logic [AW-1:0]  remaining;

  // read in flight: memory data arrives in the cycle after the issue
  logic           rd_pend;
  logic           pend_last;
  logic [AW-1:0]  pend_used;

  logic           accept;
  logic [AW-1:0]  n_words;
  logic           room;
  logic [AW-1:0]  read_index_inc;
  logic [AW-1:0]  write_index_inc;
  logic [AW:0]    skip_sum;
  logic [AW-1:0]  skip_index;
  logic           mem_we;
  logic           mem_re;
  logic [WORD_BITS-1:0] rdata;

  assign busy   = (state != ST_IDLE) || rd_pend;
  assign accept = start && !busy;

  // words actually moved by pop or skip: the count clamped to the fill
  always_comb begin
    if (CW'(item.count) < CW'(fill_level)) begin
      n_words = AW'(item.count);
    end else begin
      n_words = fill_level;
    end
  end

  assign room = fill_level != AW'(DEPTH - 1);

  // index wrap for any depth, not only powers of two
  assign read_index_inc  = (read_index == AW'(DEPTH - 1)) ? '0 : read_index + 1'b1;
  assign write_index_inc = (write_index == AW'(DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign skip_sum        = {1'b0, read_index} + {1'b0, n_words};
  assign skip_index      = (skip_sum >= (AW+1)'(DEPTH)) ? AW'(skip_sum - (AW+1)'(DEPTH))
                                                        : skip_sum[AW-1:0];

  // a push writes a free slot, a pop reads a held one, so they never collide
  assign mem_we = accept && (item.req_type == REQ_PUSH) && room;
  assign mem_re = (state == ST_POP);

  rfbps_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_index),
    .wdata (item.data),
    .re    (mem_re),
    .raddr (read_index),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      read_index  <= '0;
      write_index <= '0;
      fill_level  <= '0;
      remaining   <= '0;
      rd_pend     <= 1'b0;
      done        <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;

      // word returning from memory goes out with the counts taken at issue
      if (rd_pend) begin
        done              <= 1'b1;
        result.word_out   <= rdata;
        result.word_valid <= 1'b1;
        result.last       <= pend_last;
        result.accepted   <= 1'b0;
        result.used_count <= pend_used;
        result.free_count <= AW'(DEPTH - 1) - pend_used;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            result.word_out   <= '0;
            result.word_valid <= 1'b0;
            result.last       <= 1'b1;
            result.accepted   <= 1'b0;
            result.used_count <= fill_level;
            result.free_count <= AW'(DEPTH - 1) - fill_level;
            done              <= 1'b1;
            unique case (item.req_type)
              REQ_PUSH: begin
                if (room) begin
                  write_index       <= write_index_inc;
                  fill_level        <= fill_level + 1'b1;
                  result.accepted   <= 1'b1;
                  result.used_count <= fill_level + 1'b1;
                  result.free_count <= AW'(DEPTH - 1) - fill_level - 1'b1;
                end
              end
              REQ_POP: begin
                // nothing to give: the empty result above stands
                if (n_words != '0) begin
                  done      <= 1'b0;
                  remaining <= n_words;
                  state     <= ST_POP;
                end
              end
              REQ_SKIP: begin
                read_index        <= skip_index;
                fill_level        <= fill_level - n_words;
                result.used_count <= fill_level - n_words;
                result.free_count <= AW'(DEPTH - 1) - (fill_level - n_words);
              end
              REQ_CLEAR: begin
                read_index        <= '0;
                write_index       <= '0;
                fill_level        <= '0;
                result.used_count <= '0;
                result.free_count <= AW'(DEPTH - 1);
              end
              default: begin
              end
            endcase
          end
        end
        ST_POP: begin
          // one slot read issued per cycle
          read_index <= read_index_inc;
          fill_level <= fill_level - 1'b1;
          remaining  <= remaining - 1'b1;
          rd_pend    <= 1'b1;
          pend_last  <= (remaining == AW'(1));
          pend_used  <= fill_level - 1'b1;
          if (remaining == AW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // counts always add up to the usable capacity
  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.used_count + result.free_count) == AW'(DEPTH - 1))
    else $error("used and free counts disagree");

  // an accepted (push) result carries no popped word and is marked last
  a_accept_no_word: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (!result.word_valid && result.last))
    else $error("accepted flag on a popped word");

  // popped words stream back to back until the last one
  a_pop_stream: assert property (@(posedge clk) disable iff (rst)
    (done && result.word_valid && !result.last) |=> (done && result.word_valid))
    else $error("gap in a pop burst");

  // no new request is taken while a pop burst is running
  a_busy_pop: assert property (@(posedge clk) disable iff (rst)
    (done && result.word_valid && !result.last) |-> busy)
    else $error("block idle in the middle of a pop");

endmodule
